FILE: rtl/rws_pkg.sv
// Shared types and codes for the receive window scheduler.
package rws_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgRx1Delay = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRx1Duration = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRx2Delay = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRx2Duration = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRx2On = 3'd4;

  localparam logic [31:0] Rx1DelayReset = 32'd200;
  localparam logic [31:0] Rx1DurationReset = 32'd800;
  localparam logic [31:0] Rx2DelayReset = 32'd2200;
  localparam logic [31:0] Rx2DurationReset = 32'd1200;
  localparam logic Rx2OnReset = 1'b1;

  localparam logic [2:0] ActValidate = 3'd0;
  localparam logic [2:0] ActBegin = 3'd1;
  localparam logic [2:0] ActNext = 3'd2;
  localparam logic [2:0] ActStage = 3'd3;
  localparam logic [2:0] ActTake = 3'd4;
  localparam logic [2:0] ActSleep = 3'd5;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StInvalid = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
  localparam logic [1:0] StCapacity = 2'd3;

  localparam logic [1:0] WinRx1 = 2'd0;
  localparam logic [1:0] WinRx2 = 2'd1;
  localparam logic [1:0] WinDone = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] tx_done_time;
    logic [63:0] msg_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] window_start;
    logic [31:0] window_length;
    logic [63:0] taken_id;
  } out_item_t;

  typedef struct packed {
    logic [31:0] rx1_delay;
    logic [31:0] rx1_duration;
    logic [31:0] rx2_delay;
    logic [31:0] rx2_duration;
    logic        rx2_on;
  } profile_t;

endpackage

FILE: rtl/rws_profile_check.sv
// Window profile limit check against delay, duration, ordering and total limits.
module rws_profile_check #(
  parameter logic [31:0] MAX_DELAY_MS = 32'd10000,
  parameter logic [33:0] MAX_TOTAL_MS = 34'd10000
) (
  input  rws_pkg::profile_t profile_i,
  output logic              ok_o
);

  logic [32:0] rx1_end;
  logic [33:0] total;
  logic        delays_ok;
  logic        rx2_ok;

  assign rx1_end = {1'b0, profile_i.rx1_delay} + {1'b0, profile_i.rx1_duration};
  assign total = {2'b00, profile_i.rx1_duration} +
                 (profile_i.rx2_on ? {2'b00, profile_i.rx2_duration} : 34'd0);
  assign delays_ok = (profile_i.rx1_delay <= MAX_DELAY_MS) &&
                     (profile_i.rx2_delay <= MAX_DELAY_MS);

  always_comb begin
    if (profile_i.rx2_on) begin
      rx2_ok = (profile_i.rx2_duration != 32'd0) &&
               ({1'b0, profile_i.rx2_delay} >= rx1_end);
    end else begin
      rx2_ok = (profile_i.rx2_delay == 32'd0) && (profile_i.rx2_duration == 32'd0);
    end
  end

  assign ok_o = (profile_i.rx1_duration != 32'd0) && delays_ok && rx2_ok &&
                (total <= MAX_TOTAL_MS);

endmodule

FILE: rtl/rws_engine.sv
// Scheduler state and the combinational evaluation of one action.
module rws_engine #(
  parameter int unsigned ID_BYTES = 8,
  parameter logic [31:0] MAX_DELAY_MS = 32'd10000,
  parameter logic [33:0] MAX_TOTAL_MS = 34'd10000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  rws_pkg::in_item_t  item_i,
  input  rws_pkg::profile_t  profile_i,
  output rws_pkg::out_item_t result_o
);

  localparam logic [63:0] IdMask = (ID_BYTES >= 8) ? {64{1'b1}} :
                                   ((64'd1 << (8 * ID_BYTES)) - 64'd1);

  logic        open_q, open_d;
  logic [1:0]  win_idx_q, win_idx_d;
  logic [63:0] tx_time_q, tx_time_d;
  logic        staged_q, staged_d;
  logic        delivered_q, delivered_d;
  logic [63:0] staged_id_q, staged_id_d;
  rws_pkg::profile_t snap_q, snap_d;

  logic        profile_ok;
  logic [63:0] id;
  logic [64:0] rx1_sum;
  logic [64:0] rx2_sum;
  logic [63:0] next_start;
  logic        begin_ok;

  rws_profile_check #(
    .MAX_DELAY_MS(MAX_DELAY_MS),
    .MAX_TOTAL_MS(MAX_TOTAL_MS)
  ) u_check (
    .profile_i(profile_i),
    .ok_o     (profile_ok)
  );

  assign id = item_i.msg_id & IdMask;
  assign rx1_sum = {1'b0, item_i.tx_done_time} + {33'd0, profile_i.rx1_delay};
  assign rx2_sum = {1'b0, item_i.tx_done_time} + {33'd0, profile_i.rx2_delay};
  assign begin_ok = profile_ok && !rx1_sum[64] && !(profile_i.rx2_on && rx2_sum[64]);
  assign next_start = tx_time_q + {32'd0, (win_idx_q == rws_pkg::WinRx1) ?
                                          snap_q.rx1_delay : snap_q.rx2_delay};

  always_comb begin
    open_d = open_q;
    win_idx_d = win_idx_q;
    tx_time_d = tx_time_q;
    staged_d = staged_q;
    delivered_d = delivered_q;
    staged_id_d = staged_id_q;
    snap_d = snap_q;
    result_o = '0;
    result_o.status = rws_pkg::StInvalid;
    if (item_i.action == rws_pkg::ActValidate) begin
      result_o.status = profile_ok ? rws_pkg::StOk : rws_pkg::StInvalid;
    end else if (item_i.action == rws_pkg::ActBegin) begin
      if (begin_ok) begin
        snap_d = profile_i;
        tx_time_d = item_i.tx_done_time;
        open_d = 1'b1;
        win_idx_d = rws_pkg::WinRx1;
        staged_d = 1'b0;
        delivered_d = 1'b0;
        result_o.status = rws_pkg::StOk;
      end
    end else if (open_q) begin
      unique case (item_i.action)
        rws_pkg::ActNext: begin
          if (win_idx_q == rws_pkg::WinRx1) begin
            result_o.window_start = next_start;
            result_o.window_length = snap_q.rx1_duration;
            win_idx_d = rws_pkg::WinRx2;
            result_o.status = rws_pkg::StOk;
          end else if (win_idx_q == rws_pkg::WinRx2 && snap_q.rx2_on) begin
            result_o.window_start = next_start;
            result_o.window_length = snap_q.rx2_duration;
            win_idx_d = rws_pkg::WinDone;
            result_o.status = rws_pkg::StOk;
          end else begin
            result_o.status = rws_pkg::StEmpty;
          end
        end
        rws_pkg::ActStage: begin
          if (id == 64'd0) begin
            result_o.status = rws_pkg::StInvalid;
          end else if (staged_q) begin
            result_o.status = (staged_id_q == id) ? rws_pkg::StOk : rws_pkg::StCapacity;
          end else begin
            staged_id_d = id;
            staged_d = 1'b1;
            result_o.status = rws_pkg::StOk;
          end
        end
        rws_pkg::ActTake: begin
          if (!staged_q || delivered_q) begin
            result_o.status = rws_pkg::StEmpty;
          end else begin
            result_o.taken_id = staged_id_q;
            delivered_d = 1'b1;
            result_o.status = rws_pkg::StOk;
          end
        end
        rws_pkg::ActSleep: begin
          open_d = 1'b0;
          result_o.status = rws_pkg::StOk;
        end
        default: begin
          result_o.status = rws_pkg::StInvalid;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      win_idx_q <= rws_pkg::WinRx1;
      tx_time_q <= 64'd0;
      staged_q <= 1'b0;
      delivered_q <= 1'b0;
    end else if (step_i) begin
      open_q <= open_d;
      win_idx_q <= win_idx_d;
      tx_time_q <= tx_time_d;
      staged_q <= staged_d;
      delivered_q <= delivered_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      staged_id_q <= staged_id_d;
      snap_q <= snap_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_delivered_needs_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    delivered_q |-> staged_q)
    else $error("delivered mark set without a staged id");

  a_win_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_idx_q != 2'd3)
    else $error("window index out of range");

  a_staged_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    staged_q |-> staged_id_q != 64'd0)
    else $error("staged id is zero");

  a_rx1_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && open_q && item_i.action == rws_pkg::ActNext && win_idx_q == rws_pkg::WinRx1
    |=> win_idx_q == rws_pkg::WinRx2)
    else $error("first window did not advance the index");
`endif

endmodule

FILE: rtl/receive_window_scheduler.sv
// Top level of the receive window scheduler: config registers, input and result stages.
// A transfer accepted into the input register is evaluated from it by the engine, and its
// result is captured in the result register when the result stage is free to advance.
// Throughput: one item per cycle; both stages advance together unless the result stalls.
// Reset: asynchronous active low; the block is closed and the window profile takes its
// default values; the staged id and captured profile are written before use.
module receive_window_scheduler #(
  parameter int unsigned ID_BYTES = 8,
  parameter logic [31:0] MAX_DELAY_MS = 32'd10000,
  parameter logic [33:0] MAX_TOTAL_MS = 34'd10000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rws_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [rws_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rws_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rws_pkg::out_item_t                out_item_o
);

  rws_pkg::profile_t  profile_q;
  rws_pkg::in_item_t  in_q;
  logic               in_valid_q, in_valid_d;
  rws_pkg::out_item_t out_q;
  logic               out_valid_q, out_valid_d;
  rws_pkg::out_item_t result;
  logic               out_free;
  logic               step;
  logic               in_take;

  assign out_free = !out_valid_q || !out_stall_i;
  assign step = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      profile_q.rx1_delay <= rws_pkg::Rx1DelayReset;
      profile_q.rx1_duration <= rws_pkg::Rx1DurationReset;
      profile_q.rx2_delay <= rws_pkg::Rx2DelayReset;
      profile_q.rx2_duration <= rws_pkg::Rx2DurationReset;
      profile_q.rx2_on <= rws_pkg::Rx2OnReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rws_pkg::CfgRx1Delay:    profile_q.rx1_delay <= cfg_data_i;
        rws_pkg::CfgRx1Duration: profile_q.rx1_duration <= cfg_data_i;
        rws_pkg::CfgRx2Delay:    profile_q.rx2_delay <= cfg_data_i;
        rws_pkg::CfgRx2Duration: profile_q.rx2_duration <= cfg_data_i;
        rws_pkg::CfgRx2On:       profile_q.rx2_on <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
    if (step) begin
      out_q <= result;
    end
  end

  rws_engine #(
    .ID_BYTES    (ID_BYTES),
    .MAX_DELAY_MS(MAX_DELAY_MS),
    .MAX_TOTAL_MS(MAX_TOTAL_MS)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .profile_i(profile_q),
    .result_o (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

endmodule
